// File: rtl/cvenc_pkg.sv
// Package for the convolutional encoder: sizes, register indexes, shared types and helpers.
package cvenc_pkg;

    localparam int MAX_RATE_N       = 8;
    localparam int MAX_K            = 14;
    localparam int MIN_K            = 3;
    localparam int INFO_LENGTH_BITS = 16;
    localparam int GEN_W            = 14;
    localparam int MEM_W            = MAX_K - 1;
    localparam int POS_W            = INFO_LENGTH_BITS + 1;
    localparam int CFG_W            = 56;
    localparam int ADDR_W           = 3;

    typedef enum logic [ADDR_W-1:0] {
        REG_RATE_N     = 3'd0,
        REG_CONSTR_LEN = 3'd1,
        REG_GEN_LOW    = 3'd2,
        REG_GEN_HIGH   = 3'd3,
        REG_ZERO_TAIL  = 3'd4,
        REG_INFO_LEN   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [3:0]                  rate_n;
        logic [3:0]                  constraint_len;
        logic [CFG_W-1:0]            gen_low;
        logic [CFG_W-1:0]            gen_high;
        logic                        zero_tail;
        logic [INFO_LENGTH_BITS-1:0] info_length;
    } t_cfg;

    // One queued word: the masked window plus its frame flags.
    typedef struct packed {
        logic [MAX_K-1:0] window;
        logic             last;
        logic             terr;
    } t_qent;

    function automatic logic [3:0] eff_k(input logic [3:0] k);
        if (k < 4'(MIN_K)) begin
            return 4'(MIN_K);
        end else if (k > 4'(MAX_K)) begin
            return 4'(MAX_K);
        end
        return k;
    endfunction

    function automatic logic [3:0] eff_rate(input logic [3:0] n);
        if (n < 4'd2) begin
            return 4'd2;
        end else if (n > 4'(MAX_RATE_N)) begin
            return 4'(MAX_RATE_N);
        end
        return n;
    endfunction

endpackage

// File: rtl/cvenc_front.sv
// Front end: accepts data bits, tracks frame position and shift memory, builds the window.
module cvenc_front import cvenc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    input  logic  i_bit,
    input  logic  i_full,
    output logic  o_ready,
    output logic  o_push,
    output t_qent o_ent
);

    logic [MEM_W-1:0] r_mem, n_mem;
    logic [POS_W-1:0] r_pos, n_pos;

    logic [3:0]       k;
    logic [3:0]       k_m1;
    logic [MEM_W-1:0] mem_mask;
    logic [MAX_K-1:0] window;
    logic [POS_W-1:0] info;
    logic [POS_W-1:0] last_idx;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        k        = eff_k(i_cfg.constraint_len);
        k_m1     = k - 4'd1;
        mem_mask = (MEM_W'(1) << k_m1) - MEM_W'(1);
        window   = {r_mem & mem_mask, i_bit};
        info     = (i_cfg.info_length == '0) ? POS_W'(1) : POS_W'(i_cfg.info_length);
        last_idx = info + POS_W'(k) - POS_W'(2);

        n_mem        = window[MEM_W-1:0] & mem_mask;
        n_pos        = r_pos;
        o_ent.window = window;
        o_ent.last   = 1'b0;
        o_ent.terr   = 1'b0;

        if (!i_cfg.zero_tail) begin
            n_pos = '0;
        end else if (r_pos < info) begin
            n_pos = r_pos + POS_W'(1);
        end else if (i_bit) begin
            // nonzero tail bit: emit zeros and restart the frame
            o_ent.window = '0;
            o_ent.terr   = 1'b1;
            n_mem        = '0;
            n_pos        = '0;
        end else if (r_pos >= last_idx) begin
            o_ent.last = 1'b1;
            n_mem      = '0;
            n_pos      = '0;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem <= '0;
            r_pos <= '0;
        end else if (o_push) begin
            r_mem <= n_mem;
            r_pos <= n_pos;
        end
    end

    a_terr_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_ent.terr |=> r_pos == '0 && r_mem == '0)
        else $error("frame did not restart after tail error");

    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_ent.last |=> r_pos == '0 && r_mem == '0)
        else $error("frame did not close after last tail bit");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !(o_ent.last && o_ent.terr))
        else $error("last and tail error on one word");

endmodule

// File: rtl/cvenc_fifo.sv
// Two-entry queue between the front end and the generator back end.
module cvenc_fifo import cvenc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_qent o_ent
);

    t_qent      r_buf [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    logic do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_ent   = r_buf[r_rptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(do_pop);
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !do_pop |-> !i_push)
        else $error("push into full queue");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wptr == r_rptr)
        else $error("queue pointers disagree with count");

endmodule

// File: rtl/cvenc_back.sv
// Back end: generator parity trees and the output register.
module cvenc_back import cvenc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_empty,
    input  t_qent                 i_ent,
    output logic                  o_pop,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [MAX_RATE_N-1:0] o_tdata,
    output logic                  o_tlast,
    output logic                  o_tuser
);

    logic                  r_valid;
    logic [MAX_RATE_N-1:0] r_data;
    logic                  r_last;
    logic                  r_terr;

    logic [3:0]            k;
    logic [3:0]            n;
    logic [MAX_RATE_N-1:0] coded;
    logic [GEN_W-1:0]      gen [MAX_RATE_N];
    logic [GEN_W-1:0]      rgen [MAX_RATE_N];

    assign o_pop    = !i_empty && (!r_valid || i_tready);
    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;
    assign o_tuser  = r_terr;

    always_comb begin
        k = eff_k(i_cfg.constraint_len);
        n = eff_rate(i_cfg.rate_n);
        for (int j = 0; j < MAX_RATE_N / 2; j++) begin
            gen[j]                  = i_cfg.gen_low[j*GEN_W +: GEN_W];
            gen[j + MAX_RATE_N / 2] = i_cfg.gen_high[j*GEN_W +: GEN_W];
        end
        // reverse each generator over the low K bits
        for (int j = 0; j < MAX_RATE_N; j++) begin
            for (int i = 0; i < GEN_W; i++) begin
                if (4'(i) < k) begin
                    rgen[j][i] = gen[j][4'(k - 4'd1 - 4'(i))];
                end else begin
                    rgen[j][i] = 1'b0;
                end
            end
            coded[j] = (4'(j) < n) && (^(i_ent.window & rgen[j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= coded;
            r_last <= i_ent.last;
            r_terr <= i_ent.terr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    a_terr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_terr |-> r_data == '0)
        else $error("tail error word carries coded bits");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped word not presented");

    a_held_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_tready |-> !o_pop)
        else $error("pop while output stalled");

endmodule

// File: rtl/convolutional_encoder_core.sv
// Top level of the rate 1/n convolutional encoder: config registers, front end, queue, back end.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[0] data_bit
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata coded_bits, tlast frame_last,
//                                               tuser tail_error
//  cfg       in   i_cfg_we (no wait)            i_cfg_addr index, i_cfg_data value
//
//  One bit in and one word out per cycle while the output is not stalled; each
//  accepted bit is written into the queue by the front end, and the parity trees
//  load its word from the queue into the output register once that register is free.
//  Reset is synchronous and active low; it restores register defaults and
//  clears shift memory, frame position, queue and output valid.
//  Output stalls fill the two-entry queue, after which s_axis_tready drops.
module convolutional_encoder_core import cvenc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [ADDR_W-1:0]     i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [0] data_bit, [7:1] zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [MAX_RATE_N-1:0] m_axis_tdata,  // [7:0] coded_bits
    output logic                  m_axis_tlast,
    output logic                  m_axis_tuser   // [0] tail_error
);

    t_cfg  r_cfg;
    t_qent front_ent;
    t_qent queue_ent;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_n         <= 4'd2;
            r_cfg.constraint_len <= 4'd7;
            r_cfg.gen_low        <= CFG_W'(1982555);
            r_cfg.gen_high       <= '0;
            r_cfg.zero_tail      <= 1'b0;
            r_cfg.info_length    <= INFO_LENGTH_BITS'(88);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_RATE_N:     r_cfg.rate_n         <= i_cfg_data[3:0];
                REG_CONSTR_LEN: r_cfg.constraint_len <= i_cfg_data[3:0];
                REG_GEN_LOW:    r_cfg.gen_low        <= i_cfg_data;
                REG_GEN_HIGH:   r_cfg.gen_high       <= i_cfg_data;
                REG_ZERO_TAIL:  r_cfg.zero_tail      <= i_cfg_data[0];
                REG_INFO_LEN:   r_cfg.info_length    <= i_cfg_data[INFO_LENGTH_BITS-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    cvenc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .i_bit   (s_axis_tdata[0]),
        .i_full  (full),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_ent   (front_ent)
    );

    cvenc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (front_ent),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_ent   (queue_ent)
    );

    cvenc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (empty),
        .i_ent    (queue_ent),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

endmodule
